// ===== src/pdr_pkg.sv =====
package pdr_pkg;

	localparam int unsigned COORD_W = 32;
	localparam int unsigned OCC_W = 5;

	typedef enum logic [1:0] {
		CMD_PUSH_REAR  = 2'd0,
		CMD_POP_REAR   = 2'd1,
		CMD_PUSH_FRONT = 2'd2,
		CMD_POP_FRONT  = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] x;
		logic signed [COORD_W-1:0] y;
		logic signed [COORD_W-1:0] z;
	} point_t;

endpackage

// ===== src/point_deque_ring_core.sv =====
// Double-ended queue of DEPTH three-coordinate points held in a ring buffer in one
// synchronous memory. Each command beat pushes or pops at the rear or the front; a push
// on a full queue or a pop on an empty one is refused with a status and leaves the queue
// as it was. Every command gives exactly one result beat carrying the status, the popped
// point (zero unless a pop succeeded) and the occupancy after the command, taken modulo
// 32. A command is taken every cycle while results drain; its result is registered with the
// memory read in stage one, then in the output register. Pointers and the fill count update
// at accept, so a pop right after a push of the same entry sees the new data.
module point_deque_ring_core #(
	parameter int unsigned DEPTH = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  in_valid,
	output logic                                  in_stall,
	input  logic [1:0]                            cmd,
	input  logic signed [pdr_pkg::COORD_W-1:0]    in_x,
	input  logic signed [pdr_pkg::COORD_W-1:0]    in_y,
	input  logic signed [pdr_pkg::COORD_W-1:0]    in_z,
	output logic                                  out_valid,
	input  logic                                  out_stall,
	output logic [1:0]                            status,
	output logic signed [pdr_pkg::COORD_W-1:0]    out_x,
	output logic signed [pdr_pkg::COORD_W-1:0]    out_y,
	output logic signed [pdr_pkg::COORD_W-1:0]    out_z,
	output logic [pdr_pkg::OCC_W-1:0]             occupancy
);

	localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int unsigned CW = $clog2(DEPTH + 1);
	localparam logic [AW-1:0] LAST = AW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	pdr_pkg::point_t mem [DEPTH];
	pdr_pkg::point_t rd_data_q;
	pdr_pkg::point_t wr_point;

	logic [AW-1:0] head_q;
	logic [AW-1:0] tail_q;
	logic [CW-1:0] count_q;

	logic              valid_s1;
	pdr_pkg::status_t  status_s1;
	logic              pop_s1;
	logic [CW-1:0]     count_s1;

	logic              accept;
	logic              advance;
	logic              is_full;
	logic              no_points;
	logic              do_wr;
	logic              do_rd;
	logic [AW-1:0]     wr_addr;
	logic [AW-1:0]     rd_addr;
	logic [AW-1:0]     head_d;
	logic [AW-1:0]     tail_d;
	logic [CW-1:0]     count_d;
	pdr_pkg::status_t  status_d;
	pdr_pkg::cmd_t     cmd_in;
	pdr_pkg::point_t   pop_point;

	function automatic logic [AW-1:0] step_fwd(input logic [AW-1:0] i);
		step_fwd = (i == LAST) ? '0 : i + AW'(1);
	endfunction

	function automatic logic [AW-1:0] step_back(input logic [AW-1:0] i);
		step_back = (i == '0) ? LAST : i - AW'(1);
	endfunction

	assign cmd_in    = pdr_pkg::cmd_t'(cmd);
	assign advance   = !out_valid || !out_stall;
	assign in_stall  = valid_s1 && !advance;
	assign accept    = in_valid && !in_stall;
	assign is_full   = (count_q == FULL_CNT);
	assign no_points = (count_q == '0);
	assign wr_point  = '{x: in_x, y: in_y, z: in_z};

	always_comb begin
		head_d   = head_q;
		tail_d   = tail_q;
		count_d  = count_q;
		status_d = pdr_pkg::ST_DONE;
		do_wr    = 1'b0;
		do_rd    = 1'b0;
		wr_addr  = tail_q;
		rd_addr  = head_q;
		case (cmd_in)
			pdr_pkg::CMD_PUSH_REAR: begin
				if (is_full) begin
					status_d = pdr_pkg::ST_FULL;
				end else begin
					do_wr   = 1'b1;
					wr_addr = tail_q;
					tail_d  = step_fwd(tail_q);
					count_d = count_q + CW'(1);
				end
			end
			pdr_pkg::CMD_PUSH_FRONT: begin
				if (is_full) begin
					status_d = pdr_pkg::ST_FULL;
				end else begin
					do_wr   = 1'b1;
					head_d  = step_back(head_q);
					wr_addr = head_d;
					count_d = count_q + CW'(1);
				end
			end
			pdr_pkg::CMD_POP_REAR: begin
				if (no_points) begin
					status_d = pdr_pkg::ST_EMPTY;
				end else begin
					do_rd   = 1'b1;
					tail_d  = step_back(tail_q);
					rd_addr = tail_d;
					count_d = count_q - CW'(1);
				end
			end
			pdr_pkg::CMD_POP_FRONT: begin
				if (no_points) begin
					status_d = pdr_pkg::ST_EMPTY;
				end else begin
					do_rd   = 1'b1;
					rd_addr = head_q;
					head_d  = step_fwd(head_q);
					count_d = count_q - CW'(1);
				end
			end
			default: begin
				status_d = pdr_pkg::ST_DONE;
			end
		endcase
	end

	// point memory, one write or one read per cycle, only on an accepted command
	always_ff @(posedge clk) begin
		if (accept && do_wr) begin
			mem[wr_addr] <= wr_point;
		end
		if (accept && do_rd) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q   <= '0;
			tail_q   <= '0;
			count_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (accept) begin
				head_q  <= head_d;
				tail_q  <= tail_d;
				count_q <= count_d;
			end
			if (accept) begin
				valid_s1 <= 1'b1;
			end else if (advance) begin
				valid_s1 <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			status_s1 <= status_d;
			pop_s1    <= do_rd;
			count_s1  <= count_d;
		end
	end

	assign pop_point = pop_s1 ? rd_data_q : '0;

	// output beat register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (advance) begin
			out_valid <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && valid_s1) begin
			status    <= status_s1;
			out_x     <= pop_point.x;
			out_y     <= pop_point.y;
			out_z     <= pop_point.z;
			occupancy <= pdr_pkg::OCC_W'(count_s1);
		end
	end

endmodule
